### rtl/kms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard matrix scanner package
// Matrix dimensions, field widths and the types shared by the scanner files.
// ----------------------------------------------------------------------------
package kms_pkg;

   localparam int NUM_ROWS    = 9;
   localparam int NUM_COLUMNS = 8;

   localparam int COL_FIELD_W = 8;
   localparam int ROW_IDX_W   = 4;
   localparam int TIMEOUT_W   = 8;

   localparam logic [TIMEOUT_W-1:0]   SCAN_TIMEOUT_RESET = TIMEOUT_W'(20);
   localparam logic [NUM_ROWS-1:0]    ROW_MASK           = '1;
   localparam logic [COL_FIELD_W-1:0] COL_MASK           =
      COL_FIELD_W'((64'd1 << NUM_COLUMNS) - 64'd1);
   localparam logic [ROW_IDX_W-1:0]   LAST_ROW           = ROW_IDX_W'(NUM_ROWS - 1);

   typedef struct packed {
      logic [COL_FIELD_W-1:0] idle_columns;
      logic [COL_FIELD_W-1:0] scan_columns;
   } tick_type;

   typedef struct packed {
      logic take;
   } stage_ctl_type;

endpackage
`default_nettype wire

### rtl/kms_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard matrix scanner channel interfaces
// Tick request, scan result and timeout register write channels.
// ----------------------------------------------------------------------------
interface kms_req_if;
   import kms_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COL_FIELD_W-1:0] idle_columns;
   logic [COL_FIELD_W-1:0] scan_columns;

   modport source (output valid, idle_columns, scan_columns, input ready);
   modport sink   (input valid, idle_columns, scan_columns, output ready);
endinterface

interface kms_rsp_if;
   import kms_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [NUM_ROWS-1:0]    row_drive;
   logic                   row_scanned;
   logic [ROW_IDX_W-1:0]   scanned_row;
   logic [COL_FIELD_W-1:0] row_value;
   logic                   row_changed;

   modport source (output valid, row_drive, row_scanned, scanned_row, row_value,
                   row_changed, input ready);
   modport sink   (input valid, row_drive, row_scanned, scanned_row, row_value,
                   row_changed, output ready);
endinterface

interface kms_csr_if;
   import kms_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [TIMEOUT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/kms_input_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard matrix scanner input stage
// Registers one tick request and holds it until the scan engine takes it.
// ----------------------------------------------------------------------------
module kms_input_stage
   import kms_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   kms_req_if.sink       req_chan,
   input  wire logic     engine_take,
   output stage_ctl_type stage_ctl,
   output tick_type      tick
);

   logic     valid_ff;
   logic     valid_in;
   tick_type tick_ff;
   logic     req_fire;

   assign req_chan.ready = !valid_ff || engine_take;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign valid_in       = req_fire || (valid_ff && !engine_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tick_ff.idle_columns <= req_chan.idle_columns & COL_MASK;
         tick_ff.scan_columns <= req_chan.scan_columns & COL_MASK;
      end
   end

   assign stage_ctl.take  = valid_ff && engine_take;
   assign tick            = tick_ff;

endmodule
`default_nettype wire

### rtl/kms_scan_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard matrix scanner engine
// Holds scan state; works one tick per cycle unless stalled; registers result.
// ----------------------------------------------------------------------------
module kms_scan_engine
   import kms_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire stage_ctl_type        stage_ctl,
   input  wire tick_type             tick,
   input  wire logic [TIMEOUT_W-1:0] scan_timeout,
   output logic                      engine_take,
   kms_rsp_if.source                 rsp_chan
);

   logic [TIMEOUT_W-1:0]   count_ff,   count_in;
   logic [ROW_IDX_W-1:0]   row_ff,     row_in;
   logic                   seen_ff,    seen_in;
   logic [NUM_ROWS-1:0]    drive_ff,   drive_in;
   logic [COL_FIELD_W-1:0] last_ff [NUM_ROWS];
   logic [COL_FIELD_W-1:0] last_in [NUM_ROWS];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUM_ROWS-1:0]    drive_out_ff;
   logic                   scanned_ff,  scanned_in;
   logic [ROW_IDX_W-1:0]   srow_ff,     srow_in;
   logic [COL_FIELD_W-1:0] value_ff,    value_in;
   logic                   changed_ff,  changed_in;

   logic                   wake;
   logic                   hit;
   logic [NUM_ROWS-1:0]    drive_a;
   logic [TIMEOUT_W-1:0]   count_a;
   logic [TIMEOUT_W-1:0]   count_b;
   logic                   do_scan;
   logic [ROW_IDX_W-1:0]   row_cur;
   logic [ROW_IDX_W-1:0]   row_next;

   assign engine_take = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      wake     = (count_ff == '0) && !seen_ff;
      hit      = |tick.idle_columns;
      drive_a  = wake ? (hit ? '0 : ROW_MASK) : drive_ff;
      count_a  = (wake && hit) ? scan_timeout : count_ff;
      do_scan  = count_a != '0;
      row_cur  = (row_ff > LAST_ROW) ? '0 : row_ff;
      row_next = (row_cur == LAST_ROW) ? '0 : row_cur + ROW_IDX_W'(1);

      count_b    = count_a;
      seen_in    = seen_ff;
      drive_in   = drive_a;
      row_in     = row_ff;
      last_in    = last_ff;
      scanned_in = 1'b0;
      srow_in    = '0;
      value_in   = '0;
      changed_in = 1'b0;

      if (do_scan) begin
         if (row_cur == '0) begin
            seen_in = 1'b0;
         end
         changed_in       = last_ff[row_cur] != tick.scan_columns;
         last_in[row_cur] = tick.scan_columns;
         scanned_in       = 1'b1;
         srow_in          = row_cur;
         value_in         = tick.scan_columns;
         if (tick.scan_columns != '0) begin
            seen_in = 1'b1;
            count_b = scan_timeout;
         end
         drive_in = (drive_a & ~(NUM_ROWS'(1) << row_cur)) | (NUM_ROWS'(1) << row_next);
         row_in   = row_next;
      end

      if (changed_in) begin
         count_in = scan_timeout;
      end else if (count_b != '0) begin
         count_in = count_b - TIMEOUT_W'(1);
      end else begin
         count_in = count_b;
      end

      rsp_valid_in = stage_ctl.take || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= SCAN_TIMEOUT_RESET;
         row_ff       <= '0;
         seen_ff      <= 1'b0;
         drive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ROWS; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (stage_ctl.take) begin
            count_ff <= count_in;
            row_ff   <= row_in;
            seen_ff  <= seen_in;
            drive_ff <= drive_in;
            last_ff  <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ctl.take) begin
         drive_out_ff <= drive_in;
         scanned_ff   <= scanned_in;
         srow_ff      <= srow_in;
         value_ff     <= value_in;
         changed_ff   <= changed_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.row_drive   = drive_out_ff;
   assign rsp_chan.row_scanned = scanned_ff;
   assign rsp_chan.scanned_row = srow_ff;
   assign rsp_chan.row_value   = value_ff;
   assign rsp_chan.row_changed = changed_ff;

endmodule
`default_nettype wire

### rtl/keyboard_matrix_scanner_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard matrix scanner core
// Scans a nine-row by eight-column key matrix at most one row per tick.
//
//   Channel    Direction  Transfer carries
//   req_chan   in         idle_columns, scan_columns (one tick)
//   rsp_chan   out        row_drive, row_scanned, scanned_row, row_value,
//                         row_changed (one result per tick)
//   csr_chan   in         scan_timeout write data
//
// Every tick passes from request transfer into the input register, then
// through the scan engine into the result register, where its result is valid.
// A new tick is accepted every cycle while the result is not stalled; the
// throughput limit is the state update loop in the scan engine.
// Synchronous reset clears the scan state and sets the timeout to 20 ticks.
// A stalled result holds both stages; the input register still takes one more
// tick while the result waits.
// ----------------------------------------------------------------------------
module keyboard_matrix_scanner_core
   import kms_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   kms_req_if.sink   req_chan,
   kms_rsp_if.source rsp_chan,
   kms_csr_if.sink   csr_chan
);

   logic [TIMEOUT_W-1:0] scan_timeout_ff;
   logic [TIMEOUT_W-1:0] scan_timeout_in;
   stage_ctl_type        stage_ctl;
   tick_type             tick;
   logic                 engine_take;

   assign csr_chan.ready  = 1'b1;
   assign scan_timeout_in = csr_chan.valid ? csr_chan.data : scan_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_timeout_ff <= SCAN_TIMEOUT_RESET;
      end else begin
         scan_timeout_ff <= scan_timeout_in;
      end
   end

   kms_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .engine_take (engine_take),
      .stage_ctl   (stage_ctl),
      .tick        (tick)
   );

   kms_scan_engine u_scan_engine (
      .clock        (clock),
      .reset        (reset),
      .stage_ctl    (stage_ctl),
      .tick         (tick),
      .scan_timeout (scan_timeout_ff),
      .engine_take  (engine_take),
      .rsp_chan     (rsp_chan)
   );

endmodule
`default_nettype wire
